FILE: rtl/hce_pkg.sv
// Types, constants and the code table builder of the static Huffman encoder.
// Depends on nothing; the encoder top level, the packer and the testbench refer to it.
package hce_pkg;

  localparam int unsigned FreqCount  = 27;
  localparam int unsigned MaxSymbols = 64;
  localparam int unsigned RomIdxW    = 6;
  localparam int unsigned CodeW      = 16;
  localparam int unsigned LenW       = 5;
  localparam int unsigned EntryW     = LenW + CodeW;

  localparam logic [7:0] SpaceChar   = 8'd32;
  localparam logic [7:0] LetterBase  = 8'd97;
  localparam logic [7:0] LetterEnd   = 8'd123;
  localparam logic [4:0] SpaceSymbol = 5'd26;

  localparam int FreqTable [FreqCount] = '{
    81, 15, 28, 43, 128, 23, 20, 61, 71, 2, 1, 40, 24, 69,
    76, 20, 1, 61, 64, 91, 28, 10, 24, 1, 20, 1, 130
  };

  typedef logic [EntryW-1:0] entry_t;
  typedef entry_t [MaxSymbols-1:0] rom_t;

  typedef struct packed {
    logic sym_ok;
    logic finish;
  } pack_req_t;

  // Builds the code table for n symbols. Each entry holds the length in the upper
  // bits and the code, right-aligned, in the lower bits.
  function automatic rom_t build_rom(input int n, input int max_len);
    int   val        [MaxSymbols];
    logic live       [MaxSymbols];
    int   slot_node  [MaxSymbols];
    int   parent     [2*MaxSymbols];
    logic side       [2*MaxSymbols];
    logic has_parent [2*MaxSymbols];
    logic path       [2*MaxSymbols];
    int   remaining;
    int   nxt;
    int   a;
    int   b;
    int   node;
    int   depth;
    int   len;
    logic [CodeW-1:0] code;
    rom_t rom;
    rom       = '0;
    remaining = n;
    nxt       = n;
    for (int i = 0; i < 2 * MaxSymbols; i++) begin
      parent[i]     = 0;
      side[i]       = 1'b0;
      has_parent[i] = 1'b0;
      path[i]       = 1'b0;
    end
    for (int i = 0; i < MaxSymbols; i++) begin
      val[i]       = (i < FreqCount) ? FreqTable[i] : 1;
      live[i]      = (i < n);
      slot_node[i] = i;
    end
    while (remaining > 1 && nxt < 2 * n) begin
      a = -1;
      for (int i = 0; i < MaxSymbols; i++) begin
        if (live[i] && (a < 0 || val[i] < val[a])) a = i;
      end
      b = -1;
      for (int i = 0; i < MaxSymbols; i++) begin
        if (live[i] && i != a && (b < 0 || val[i] < val[b])) b = i;
      end
      if (a < 0 || b < 0) begin
        remaining = 1;
      end else begin
        parent[slot_node[b]]     = nxt;
        side[slot_node[b]]       = 1'b0;
        has_parent[slot_node[b]] = 1'b1;
        parent[slot_node[a]]     = nxt;
        side[slot_node[a]]       = 1'b1;
        has_parent[slot_node[a]] = 1'b1;
        slot_node[a] = nxt;
        val[a]       = val[a] + val[b];
        live[b]      = 1'b0;
        nxt++;
        remaining--;
      end
    end
    for (int s = 0; s < MaxSymbols; s++) begin
      if (s < n) begin
        node  = s;
        depth = 0;
        while (has_parent[node] && depth < 2 * n) begin
          path[depth] = side[node];
          depth++;
          node = parent[node];
        end
        len  = (depth > max_len) ? max_len : depth;
        code = '0;
        for (int k = 0; k < len; k++) begin
          code = {code[CodeW-2:0], path[depth-1-k]};
        end
        rom[s] = {LenW'(len), code};
      end
    end
    return rom;
  endfunction

endpackage

FILE: rtl/hce_if.sv
// Valid/ready channel interfaces of the static Huffman encoder.
// Self-contained; used by the top level and the byte packer.
interface hce_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       finish;

  modport source (output valid, output char_code, output finish, input ready);
  modport sink (input valid, input char_code, input finish, output ready);
endinterface

interface hce_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;

  modport source (output valid, output out_byte, output run_last, input ready);
  modport sink (input valid, input out_byte, input run_last, output ready);
endinterface

FILE: rtl/static_huffman_encoder.sv
// Static Huffman encoder for lowercase text and space, packing codes MSB first into bytes.
// Depends on hce_pkg, hce_if, hce_ram and hce_pack.
//
// Usage: requests on in_i carry one character byte and a finish flag. Letters a-z and
// space are encoded; any other byte adds no bits. Results on out_o are packed bytes,
// first code bit in the MSB; run_last marks the last byte a request produced. With
// finish set, a partial byte is zero-padded and sent. A request may produce zero to
// three bytes.
// After reset the code table RAM is loaded from the constant table, one entry per
// cycle; in_i.ready stays low until that is done.
// The table is read at the edge that accepts a request; the packer registers its
// bytes once it takes the request from the read stage, and then offers the first
// byte on out_o. The sustained rate is set by the single output port: one byte per
// cycle while the receiver is ready. The next request is read from the table while
// earlier bytes drain. When the receiver stalls, the queued bytes hold, one further
// request waits in the table read stage, and then in_i.ready drops.
module static_huffman_encoder #(
  parameter int unsigned SYMBOLS      = 27,
  parameter int unsigned MAX_CODE_LEN = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  hce_in_if.sink    in_i,
  hce_out_if.source out_o
);

  localparam int unsigned SymW    = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
  localparam int unsigned FillW   = $clog2(SYMBOLS + 1);
  localparam int unsigned RomIdxW = hce_pkg::RomIdxW;
  localparam hce_pkg::rom_t RomInit = hce_pkg::build_rom(SYMBOLS, MAX_CODE_LEN);

  logic [FillW-1:0]   fill_q, fill_d;
  logic               fill_done;
  logic [RomIdxW-1:0] rom_idx;
  logic               is_letter;
  logic [4:0]         raw_sym;
  logic               sym_ok;
  logic               accept;
  logic               s1_valid_q, s1_valid_d;
  hce_pkg::pack_req_t s1_req_q;
  hce_pkg::entry_t    rd_entry;
  logic               pack_ready;
  logic               pack_load;

  assign fill_done = (fill_q == FillW'(SYMBOLS));
  assign fill_d    = fill_done ? fill_q : fill_q + FillW'(1);
  assign rom_idx   = RomIdxW'(fill_q);

  assign is_letter = (in_i.char_code >= hce_pkg::LetterBase) &&
                     (in_i.char_code < hce_pkg::LetterEnd);
  assign raw_sym   = is_letter ? 5'(in_i.char_code - hce_pkg::LetterBase)
                               : hce_pkg::SpaceSymbol;
  assign sym_ok    = (is_letter || (in_i.char_code == hce_pkg::SpaceChar)) &&
                     (32'(raw_sym) < SYMBOLS);

  assign in_i.ready = fill_done && (!s1_valid_q || pack_ready);
  assign accept     = in_i.valid && in_i.ready;
  assign pack_load  = s1_valid_q && pack_ready;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (pack_ready) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q     <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      fill_q     <= fill_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_req_q.sym_ok <= sym_ok;
      s1_req_q.finish <= in_i.finish;
    end
  end

  hce_ram #(
    .Width (hce_pkg::EntryW),
    .Depth (SYMBOLS)
  ) u_code_ram (
    .clk_i     (clk_i),
    .wr_en_i   (!fill_done),
    .wr_addr_i (fill_q[SymW-1:0]),
    .wr_data_i (RomInit[rom_idx]),
    .rd_en_i   (accept && sym_ok),
    .rd_addr_i (SymW'(raw_sym)),
    .rd_data_o (rd_entry)
  );

  hce_pack u_pack (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (pack_load),
    .req_i   (s1_req_q),
    .entry_i (rd_entry),
    .ready_o (pack_ready),
    .out_o   (out_o)
  );

  a_no_accept_in_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |-> fill_done)
    else $error("Request accepted before the code table was loaded.");

  a_no_stage_in_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fill_done |-> !s1_valid_q)
    else $error("Read stage busy while the code table is being loaded.");

  a_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !pack_ready |=> s1_valid_q)
    else $error("Stalled request left the read stage without being packed.");

endmodule

FILE: rtl/hce_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Self-contained; holds the code table of the encoder.
module hce_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic                                     clk_i,
  input  logic                                     wr_en_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] wr_addr_i,
  input  logic [Width-1:0]                         wr_data_i,
  input  logic                                     rd_en_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] rd_addr_i,
  output logic [Width-1:0]                         rd_data_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

FILE: rtl/hce_pack.sv
// Bit packer: merges a code into the held bits, queues up to three bytes and drains them.
// Depends on hce_pkg and hce_out_if.
module hce_pack (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  hce_pkg::pack_req_t req_i,
  input  hce_pkg::entry_t   entry_i,
  output logic              ready_o,
  hce_out_if.source         out_o
);

  logic [6:0]  acc_q, acc_d;
  logic [2:0]  held_q, held_d;
  logic [1:0]  cnt_q, cnt_d;
  logic [7:0]  byte_q [3];
  logic [7:0]  byte_d [3];
  logic [15:0] code;
  logic [4:0]  len;
  logic [22:0] bits;
  logic [4:0]  total;
  logic [23:0] aligned;
  logic [2:0]  rem;
  logic        flush;
  logic        pop;

  assign pop     = (cnt_q != 2'd0) && out_o.ready;
  assign ready_o = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && out_o.ready);

  assign out_o.valid    = (cnt_q != 2'd0);
  assign out_o.out_byte = byte_q[0];
  assign out_o.run_last = (cnt_q == 2'd1);

  always_comb begin
    code    = req_i.sym_ok ? entry_i[hce_pkg::CodeW-1:0] : 16'd0;
    len     = req_i.sym_ok ? entry_i[hce_pkg::EntryW-1:hce_pkg::CodeW] : 5'd0;
    bits    = ({16'd0, acc_q} << len) | {7'd0, code};
    total   = {2'd0, held_q} + len;
    aligned = {1'b0, bits} << (5'd24 - total);
    rem     = total[2:0];
    flush   = req_i.finish && (rem != 3'd0);

    acc_d  = acc_q;
    held_d = held_q;
    cnt_d  = cnt_q;
    byte_d = byte_q;
    if (pop) begin
      byte_d[0] = byte_q[1];
      byte_d[1] = byte_q[2];
      cnt_d     = cnt_q - 2'd1;
    end
    if (load_i) begin
      byte_d[0] = aligned[23:16];
      byte_d[1] = aligned[15:8];
      byte_d[2] = aligned[7:0];
      cnt_d     = total[4:3] + {1'b0, flush};
      if (req_i.finish) begin
        acc_d  = 7'd0;
        held_d = 3'd0;
      end else begin
        acc_d  = bits[6:0] & ~(7'h7f << rem);
        held_d = rem;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= 7'd0;
      held_q <= 3'd0;
      cnt_q  <= 2'd0;
    end else begin
      acc_q  <= acc_d;
      held_q <= held_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  a_load_when_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> ready_o)
    else $error("Packer loaded while bytes were still queued.");

  a_finish_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i && req_i.finish |=> held_q == 3'd0)
    else $error("Bits remain held after a finishing request.");

  a_acc_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc_q >> held_q) == 7'd0)
    else $error("Accumulator has bits above the held count.");

  a_drop_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i && !req_i.sym_ok && !req_i.finish |=> cnt_q == 2'd0)
    else $error("A dropped character produced output bytes.");

endmodule

FILE: tb/hce_byte_checker.sv
// Checker of the static Huffman encoder: watches the request and result channels,
// predicts the packed bytes of every accepted request and compares them in order.
// Depends on hce_pkg and the channel interfaces in hce_if.
module hce_byte_checker #(
  parameter int unsigned NUM_SYM  = 27,
  parameter int unsigned CODE_CAP = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  hce_in_if    req_i,
  hce_out_if   rsp_i,
  output int   mismatches_o,
  output int   pending_o,
  output int   chars_o,
  output int   bytes_o
);

  localparam int unsigned NumFreq = 27;
  localparam int LetterFreq [NumFreq] = '{
    81, 15, 28, 43, 128, 23, 20, 61, 71, 2, 1, 40, 24, 69,
    76, 20, 1, 61, 64, 91, 28, 10, 24, 1, 20, 1, 130
  };

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } packed_byte_t;

  typedef struct {
    logic [hce_pkg::CodeW-1:0] bits;
    int                        len;
  } huff_code_t;

  huff_code_t   code_table [NUM_SYM];
  packed_byte_t expected_bytes [$];
  packed_byte_t want;
  logic [7:0]   shift_acc;
  int           shift_cnt;
  int           mism;
  int           n_chars;
  int           n_bytes;

  // Merges the two lightest live subtrees until one is left; the lighter one
  // becomes the right child and keeps its slot. Codes are then read off the root paths.
  function automatic void make_code_table();
    int weight  [NUM_SYM];
    bit alive   [NUM_SYM];
    int root_of [NUM_SYM];
    int up      [2*NUM_SYM];
    bit branch  [2*NUM_SYM];
    bit linked  [2*NUM_SYM];
    bit trail   [2*NUM_SYM];
    int lo;
    int lo2;
    int fresh;
    int live_cnt;
    int node;
    int depth;
    for (int i = 0; i < 2 * NUM_SYM; i++) begin
      up[i]     = 0;
      branch[i] = 1'b0;
      linked[i] = 1'b0;
      trail[i]  = 1'b0;
    end
    for (int i = 0; i < NUM_SYM; i++) begin
      weight[i]  = (i < NumFreq) ? LetterFreq[i] : 1;
      alive[i]   = 1'b1;
      root_of[i] = i;
    end
    live_cnt = NUM_SYM;
    fresh    = NUM_SYM;
    while (live_cnt > 1) begin
      lo = -1;
      for (int i = 0; i < NUM_SYM; i++) begin
        if (alive[i] && (lo < 0 || weight[i] < weight[lo])) lo = i;
      end
      lo2 = -1;
      for (int i = 0; i < NUM_SYM; i++) begin
        if (alive[i] && i != lo && (lo2 < 0 || weight[i] < weight[lo2])) lo2 = i;
      end
      up[root_of[lo2]]     = fresh;
      branch[root_of[lo2]] = 1'b0;
      linked[root_of[lo2]] = 1'b1;
      up[root_of[lo]]      = fresh;
      branch[root_of[lo]]  = 1'b1;
      linked[root_of[lo]]  = 1'b1;
      root_of[lo] = fresh;
      weight[lo]  = weight[lo] + weight[lo2];
      alive[lo2]  = 1'b0;
      fresh++;
      live_cnt--;
    end
    for (int s = 0; s < NUM_SYM; s++) begin
      node  = s;
      depth = 0;
      while (linked[node]) begin
        trail[depth] = branch[node];
        depth++;
        node = up[node];
      end
      code_table[s].len  = (depth > int'(CODE_CAP)) ? int'(CODE_CAP) : depth;
      code_table[s].bits = '0;
      for (int k = 0; k < code_table[s].len; k++) begin
        code_table[s].bits = {code_table[s].bits[hce_pkg::CodeW-2:0], trail[depth-1-k]};
      end
    end
  endfunction

  function automatic void encode_char(input logic [7:0] ch, input logic fin);
    int         sym;
    int         first_new;
    huff_code_t hc;
    first_new = expected_bytes.size();
    sym = -1;
    if (ch >= hce_pkg::LetterBase && ch < hce_pkg::LetterEnd) begin
      sym = int'(ch - hce_pkg::LetterBase);
    end else if (ch == hce_pkg::SpaceChar) begin
      sym = int'(hce_pkg::SpaceSymbol);
    end
    if (sym >= int'(NUM_SYM)) sym = -1;
    if (sym >= 0) begin
      hc = code_table[sym];
      for (int k = hc.len - 1; k >= 0; k--) begin
        shift_acc = {shift_acc[6:0], hc.bits[k]};
        shift_cnt++;
        if (shift_cnt == 8) begin
          expected_bytes.push_back(packed_byte_t'{data: shift_acc, last: 1'b0});
          shift_acc = '0;
          shift_cnt = 0;
        end
      end
    end
    if (fin && shift_cnt != 0) begin
      expected_bytes.push_back(packed_byte_t'{data: 8'(shift_acc << (8 - shift_cnt)),
                                              last: 1'b0});
      shift_acc = '0;
      shift_cnt = 0;
    end
    if (expected_bytes.size() > first_new) expected_bytes[$].last = 1'b1;
  endfunction

  initial make_code_table();

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_acc = '0;
      shift_cnt = 0;
      mism      = 0;
      n_chars   = 0;
      n_bytes   = 0;
      expected_bytes.delete();
      mismatches_o <= 0;
      pending_o    <= 0;
      chars_o      <= 0;
      bytes_o      <= 0;
    end else begin
      if (rsp_i.valid && rsp_i.ready) begin
        n_bytes++;
        if (expected_bytes.size() == 0) begin
          mism++;
          if (mism <= 10) begin
            $display("%0t: unexpected byte %02h run_last %0b", $time, rsp_i.out_byte,
                     rsp_i.run_last);
          end
        end else begin
          want = expected_bytes.pop_front();
          if (rsp_i.out_byte !== want.data || rsp_i.run_last !== want.last) begin
            mism++;
            if (mism <= 10) begin
              $display("%0t: byte %0d expected %02h/%0b, got %02h/%0b", $time, n_bytes,
                       want.data, want.last, rsp_i.out_byte, rsp_i.run_last);
            end
          end
        end
      end
      if (req_i.valid && req_i.ready) begin
        n_chars++;
        encode_char(req_i.char_code, req_i.finish);
      end
      mismatches_o <= mism;
      pending_o    <= expected_bytes.size();
      chars_o      <= n_chars;
      bytes_o      <= n_bytes;
    end
  end

endmodule

FILE: tb/tb.sv
// Top of the static Huffman encoder testbench: clock, reset, character stimulus
// under changing pacing, and the verdict. Depends on hce_pkg, hce_if, the encoder
// and hce_byte_checker.
module tb;

  localparam int unsigned NumSym = 27;
  localparam int unsigned MaxLen = 16;

  logic clk_i;
  logic rst_ni;
  int   tx_gap_pct;
  int   rx_stall_pct;
  int   mismatches;
  int   pending;
  int   chars_seen;
  int   bytes_seen;

  hce_in_if  req_if ();
  hce_out_if rsp_if ();

  static_huffman_encoder #(
    .SYMBOLS     (NumSym),
    .MAX_CODE_LEN(MaxLen)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (req_if),
    .out_o (rsp_if)
  );

  hce_byte_checker #(
    .NUM_SYM (NumSym),
    .CODE_CAP(MaxLen)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_if),
    .rsp_i       (rsp_if),
    .mismatches_o(mismatches),
    .pending_o   (pending),
    .chars_o     (chars_seen),
    .bytes_o     (bytes_seen)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    rsp_if.ready <= ($urandom_range(99) >= rx_stall_pct);
  end

  // Leaves valid high into the next request when there is no gap.
  task automatic send_char(input logic [7:0] ch, input logic fin);
    while ($urandom_range(99) < tx_gap_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid     <= 1'b1;
    req_if.char_code <= ch;
    req_if.finish    <= fin;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  initial begin
    rst_ni           = 1'b0;
    req_if.valid     = 1'b0;
    req_if.char_code = '0;
    req_if.finish    = 1'b0;
    tx_gap_pct       = 18;
    rx_stall_pct     = 48;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Finish with nothing held, bytes just outside the encoded ranges, and the
    // rarest letters, whose codes are the longest.
    send_char(8'h00, 1'b1);
    send_char(8'hff, 1'b0);
    send_char(hce_pkg::SpaceChar - 8'd1, 1'b0);
    send_char(hce_pkg::SpaceChar + 8'd1, 1'b0);
    send_char(hce_pkg::LetterBase - 8'd1, 1'b0);
    send_char(hce_pkg::LetterEnd, 1'b0);
    send_char(8'd127, 1'b0);
    send_char(8'd128, 1'b0);
    send_char("a", 1'b0);
    send_char("z", 1'b1);
    send_char(hce_pkg::SpaceChar, 1'b1);
    send_char("e", 1'b0);
    send_char("q", 1'b0);
    send_char("x", 1'b0);
    send_char("z", 1'b0);
    send_char(8'hff, 1'b1);
    send_char("k", 1'b0);
    send_char("j", 1'b0);
    send_char("q", 1'b0);
    send_char("z", 1'b1);
    send_char(8'hff, 1'b1);

    for (int phase = 0; phase < 3; phase++) begin
      tx_gap_pct   = (phase == 0) ? 18 : (phase == 1) ? 48 : 0;
      rx_stall_pct = (phase == 0) ? 48 : (phase == 1) ? 18 : 0;
      if (phase == 0) begin
        for (int s = 0; s < 26; s++) send_char(hce_pkg::LetterBase + 8'(s), 1'b0);
        send_char(hce_pkg::SpaceChar, 1'b1);
      end
      for (int n = 0; n < 44; n++) begin
        int         pick;
        logic [7:0] ch;
        logic       fin;
        pick = $urandom_range(99);
        if (pick < 72) begin
          ch = hce_pkg::LetterBase + 8'($urandom_range(25));
        end else if (pick < 86) begin
          ch = hce_pkg::SpaceChar;
        end else begin
          ch = 8'($urandom_range(255));
        end
        fin = ($urandom_range(9) == 0);
        send_char(ch, fin);
      end
    end
    req_if.valid <= 1'b0;

    do @(posedge clk_i); while (pending != 0);
    repeat (20) @(posedge clk_i);

    $display("Encoded %0d characters: edge bytes, all 27 symbols, random text with flushes,",
             chars_seen);
    $display("under sender gaps, receiver stalls and back-to-back traffic; %0d bytes compared.",
             bytes_seen);
    if (mismatches == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("Timeout: the encoder stopped making progress.");
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
